// ===== hdl/pm25_average_fan_level_top_assert.svh =====
// assertion macros for the pm25 average / fan level block
// used by the port checker; no other dependencies
`ifndef PM25_AVERAGE_FAN_LEVEL_TOP_ASSERT_SVH
`define PM25_AVERAGE_FAN_LEVEL_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define PM25_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pm25 check failed");

// next-cycle implication, off during reset
`define PM25_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pm25 check failed");

// next-cycle implication that also runs through reset
`define PM25_ASSERT_NEXT_ANY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pm25 check failed");

`endif

// ===== hdl/pm25_pkg.sv =====
// shared types and constants for the pm25 average / fan level block
// no dependencies
package pm25_pkg;

  // window geometry
  localparam int WINDOW_LEN = 5;
  localparam int SLOT_W     = $clog2(WINDOW_LEN);
  localparam int COUNT_W    = $clog2(WINDOW_LEN + 1);

  // field widths
  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 16;
  localparam int THR_W    = 12;
  localparam int HYST_W   = 8;
  localparam int LEVEL_W  = 2;
  localparam int CMP_W    = THR_W + 2;

  // divide by window length as multiply by rounded-up reciprocal and shift
  localparam int    DIV_SHIFT = SUM_W + $clog2(WINDOW_LEN);
  localparam int    MUL_W     = SUM_W + 2;
  localparam int    PROD_W    = SUM_W + MUL_W;
  localparam longint DIV_MUL_L =
    ((longint'(1) << DIV_SHIFT) + longint'(WINDOW_LEN) - 1) / longint'(WINDOW_LEN);
  localparam logic [MUL_W-1:0] DIV_MUL = MUL_W'(DIV_MUL_L);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS     = 2'd2;

  // reset values of the registers
  localparam logic [THR_W-1:0]  LOW_THRESHOLD_RST  = 12'd75;
  localparam logic [THR_W-1:0]  HIGH_THRESHOLD_RST = 12'd150;
  localparam logic [HYST_W-1:0] HYSTERESIS_RST     = 8'd5;

  // level request codes
  localparam logic [LEVEL_W-1:0] LEVEL_NONE  = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE   = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_TWO   = 2'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_THREE = 2'd3;

  // item handed from the front to the back
  typedef struct packed {
    logic             window_full;
    logic             fan_off;
    logic [SUM_W-1:0] sum;
  } work_item_t;

  // one result entry
  typedef struct packed {
    logic                window_full;
    logic [SAMPLE_W-1:0] average;
    logic [LEVEL_W-1:0]  level_request;
    logic                clear_auto;
  } result_t;

  // thresholds as seen by the back part
  typedef struct packed {
    logic [THR_W-1:0]  low_threshold;
    logic [THR_W-1:0]  high_threshold;
    logic [HYST_W-1:0] hysteresis;
  } thresholds_t;

endpackage

// ===== hdl/pm25_front.sv =====
// front part: accepts samples and keeps the ring window and its sum
// depends on pm25_pkg
module pm25_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [pm25_pkg::SAMPLE_W-1:0] sample,
  input  logic                          sensor_running,
  input  logic                          auto_request,
  input  logic                          fan_off,
  input  logic                          q_full,
  output logic                          q_push,
  output pm25_pkg::work_item_t          q_item
);

  logic [pm25_pkg::SAMPLE_W-1:0] window_store [pm25_pkg::WINDOW_LEN];
  logic [pm25_pkg::SUM_W-1:0]    window_sum, window_sum_next;
  logic [pm25_pkg::SLOT_W-1:0]   write_slot, write_slot_next;
  logic [pm25_pkg::COUNT_W-1:0]  fill_count, fill_count_next;
  logic                          accept;
  logic                          enabled;
  logic                          filling;
  logic [pm25_pkg::SLOT_W-1:0]   slot_inc;
  logic [pm25_pkg::SUM_W-1:0]    old_ext, new_ext;

  assign full    = q_full;
  assign accept  = push && !q_full;
  assign enabled = sensor_running || auto_request;
  assign filling = fill_count < pm25_pkg::COUNT_W'(pm25_pkg::WINDOW_LEN);
  assign old_ext = pm25_pkg::SUM_W'(window_store[write_slot]);
  assign new_ext = pm25_pkg::SUM_W'(sample);

  // ring position wraps at the window length
  assign slot_inc = (write_slot == pm25_pkg::SLOT_W'(pm25_pkg::WINDOW_LEN - 1)) ?
                    '0 : write_slot + 1'b1;

  // window bookkeeping for one accepted sample
  always_comb begin
    window_sum_next = window_sum;
    write_slot_next = write_slot;
    fill_count_next = fill_count;
    if (!enabled) begin
      window_sum_next = '0;
      write_slot_next = '0;
      fill_count_next = '0;
    end else if (filling) begin
      window_sum_next = window_sum + new_ext;
      write_slot_next = slot_inc;
      fill_count_next = fill_count + 1'b1;
    end else begin
      window_sum_next = window_sum - old_ext + new_ext;
      write_slot_next = slot_inc;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum <= '0;
      write_slot <= '0;
      fill_count <= '0;
    end else if (accept) begin
      window_sum <= window_sum_next;
      write_slot <= write_slot_next;
      fill_count <= fill_count_next;
    end
  end

  // sample store, written at the ring position
  always_ff @(posedge clk) begin
    if (accept && enabled) begin
      window_store[write_slot] <= sample;
    end
  end

  // hand the classified item to the queue
  assign q_push              = accept;
  assign q_item.window_full  = enabled && !filling;
  assign q_item.fan_off      = fan_off;
  assign q_item.sum          = window_sum_next;

endmodule

// ===== hdl/pm25_queue.sv =====
// two-entry queue between the front and the back part
// depends on pm25_pkg
module pm25_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr,
  input  pm25_pkg::work_item_t wr_item,
  output logic                 q_full,
  input  logic                 rd,
  output logic                 rd_valid,
  output pm25_pkg::work_item_t rd_item
);

  pm25_pkg::work_item_t entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_wr, do_rd;

  assign q_full   = count == 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_item  = entries[rd_ptr];
  assign do_wr    = wr && !q_full;
  assign do_rd    = rd && rd_valid;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= !wr_ptr;
      if (do_rd) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_item;
    end
  end

endmodule

// ===== hdl/pm25_back.sv =====
// back part: average by reciprocal multiply, level decision, result queue
// holds the configuration registers; depends on pm25_pkg
module pm25_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [pm25_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [pm25_pkg::THR_W-1:0]          wr_data,
  input  logic                                q_valid,
  input  pm25_pkg::work_item_t                q_item,
  output logic                                q_pop,
  input  logic                                pop,
  output logic                                empty,
  output logic                                window_full,
  output logic [pm25_pkg::SAMPLE_W-1:0]       average,
  output logic [pm25_pkg::LEVEL_W-1:0]        level_request,
  output logic                                clear_auto
);

  pm25_pkg::thresholds_t       thr;
  logic                        a_valid;
  logic                        a_window_full;
  logic                        a_fan_off;
  logic [pm25_pkg::PROD_W-1:0] a_prod;
  logic                        a_en;
  logic                        out_ready;
  logic                        out_push;
  logic                        out_pop;
  pm25_pkg::result_t           res;
  pm25_pkg::result_t           out_mem [2];
  logic                        out_wr_ptr, out_rd_ptr;
  logic [1:0]                  out_count;
  logic [pm25_pkg::SAMPLE_W-1:0] avg;
  logic signed [pm25_pkg::CMP_W-1:0] avg_s, lo_m, lo_p, hi_m, hi_p;
  logic [pm25_pkg::LEVEL_W-1:0] level;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr.low_threshold  <= pm25_pkg::LOW_THRESHOLD_RST;
      thr.high_threshold <= pm25_pkg::HIGH_THRESHOLD_RST;
      thr.hysteresis     <= pm25_pkg::HYSTERESIS_RST;
    end else if (wr_en) begin
      case (wr_index)
        pm25_pkg::REG_LOW_THRESHOLD:  thr.low_threshold  <= wr_data;
        pm25_pkg::REG_HIGH_THRESHOLD: thr.high_threshold <= wr_data;
        pm25_pkg::REG_HYSTERESIS:     thr.hysteresis     <= wr_data[pm25_pkg::HYST_W-1:0];
        default: ;
      endcase
    end
  end

  // multiply stage advances when it is empty or the result queue has room
  assign out_ready = out_count != 2'd2;
  assign a_en      = !a_valid || out_ready;
  assign q_pop     = q_valid && a_en;
  assign out_push  = a_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_en) begin
      a_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_window_full <= q_item.window_full;
      a_fan_off     <= q_item.fan_off;
      a_prod        <= pm25_pkg::PROD_W'(q_item.sum) * pm25_pkg::PROD_W'(pm25_pkg::DIV_MUL);
    end
  end

  // quotient and signed band edges
  assign avg   = a_prod[pm25_pkg::DIV_SHIFT +: pm25_pkg::SAMPLE_W];
  assign avg_s = signed'(pm25_pkg::CMP_W'(avg));
  assign lo_m  = signed'(pm25_pkg::CMP_W'(thr.low_threshold) - pm25_pkg::CMP_W'(thr.hysteresis));
  assign lo_p  = signed'(pm25_pkg::CMP_W'(thr.low_threshold) + pm25_pkg::CMP_W'(thr.hysteresis));
  assign hi_m  = signed'(pm25_pkg::CMP_W'(thr.high_threshold) - pm25_pkg::CMP_W'(thr.hysteresis));
  assign hi_p  = signed'(pm25_pkg::CMP_W'(thr.high_threshold) + pm25_pkg::CMP_W'(thr.hysteresis));

  // level decision with dead bands
  always_comb begin
    if (a_fan_off || avg_s <= lo_m) begin
      level = pm25_pkg::LEVEL_ONE;
    end else if (avg_s >= lo_p && avg_s <= hi_m) begin
      level = pm25_pkg::LEVEL_TWO;
    end else if (avg_s >= hi_p) begin
      level = pm25_pkg::LEVEL_THREE;
    end else begin
      level = pm25_pkg::LEVEL_NONE;
    end
  end

  // results during fill or while disabled are all zero
  always_comb begin
    res = '0;
    if (a_window_full) begin
      res.window_full   = 1'b1;
      res.average       = avg;
      res.level_request = level;
      res.clear_auto    = 1'b1;
    end
  end

  // result queue
  assign out_pop = pop && !empty;
  assign empty   = out_count == 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr_ptr <= 1'b0;
      out_rd_ptr <= 1'b0;
      out_count  <= 2'd0;
    end else begin
      if (out_push) out_wr_ptr <= !out_wr_ptr;
      if (out_pop)  out_rd_ptr <= !out_rd_ptr;
      out_count <= out_count + {1'b0, out_push} - {1'b0, out_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (out_push) begin
      out_mem[out_wr_ptr] <= res;
    end
  end

  assign window_full   = out_mem[out_rd_ptr].window_full;
  assign average       = out_mem[out_rd_ptr].average;
  assign level_request = out_mem[out_rd_ptr].level_request;
  assign clear_auto    = out_mem[out_rd_ptr].clear_auto;

endmodule

// ===== hdl/pm25_average_fan_level_top.sv =====
// Particulate moving average with fan level request.
// Input channel: sample, sensor_running, auto_request, fan_off; a transfer
// happens on a clock edge with push high and full low.
// Result channel: window_full, average, level_request, clear_auto show the
// oldest result while empty is low; pop with empty low completes the transfer.
// Config: wr_en writes wr_data into register wr_index (0 low threshold,
// 1 high threshold, 2 hysteresis) at once; write only while the block is idle.
// Every accepted sample yields exactly one result. With sensor_running and
// auto_request both low the window is emptied and the result is all zero;
// while the five-entry window fills the result is all zero as well.
// A result passes through the front queue, then the reciprocal multiply
// register, then the result queue before it is visible.
// Throughput: one sample per cycle while full is low, set by the ring update.
// Reset (rst, synchronous) empties the window and both queues and restores
// the register defaults 75, 150 and 5.
// When pop stays low the result queue (2 entries) and the front queue
// (2 entries) fill, and full rises; nothing is dropped.
// depends on pm25_pkg, pm25_front, pm25_queue, pm25_back
module pm25_average_fan_level_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [pm25_pkg::SAMPLE_W-1:0]  sample,
  input  logic                           sensor_running,
  input  logic                           auto_request,
  input  logic                           fan_off,
  output logic                           empty,
  input  logic                           pop,
  output logic                           window_full,
  output logic [pm25_pkg::SAMPLE_W-1:0]  average,
  output logic [pm25_pkg::LEVEL_W-1:0]   level_request,
  output logic                           clear_auto,
  input  logic                           wr_en,
  input  logic [pm25_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [pm25_pkg::THR_W-1:0]     wr_data
);

  logic                 q_full;
  logic                 q_push;
  pm25_pkg::work_item_t q_wr_item;
  logic                 q_pop;
  logic                 q_valid;
  pm25_pkg::work_item_t q_rd_item;

  // window keeper
  pm25_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .sample         (sample),
    .sensor_running (sensor_running),
    .auto_request   (auto_request),
    .fan_off        (fan_off),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_wr_item)
  );

  // decoupling queue
  pm25_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_push),
    .wr_item  (q_wr_item),
    .q_full   (q_full),
    .rd       (q_pop),
    .rd_valid (q_valid),
    .rd_item  (q_rd_item)
  );

  // average and level decision
  pm25_back u_back (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .q_valid       (q_valid),
    .q_item        (q_rd_item),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .window_full   (window_full),
    .average       (average),
    .level_request (level_request),
    .clear_auto    (clear_auto)
  );

endmodule

// ===== hdl/pm25_checker.sv =====
// port-level checks for the pm25 average / fan level block, bound to the top
// depends on pm25_pkg and pm25_average_fan_level_top_assert.svh
`include "pm25_average_fan_level_top_assert.svh"

module pm25_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          full,
  input logic                          empty,
  input logic                          pop,
  input logic                          window_full,
  input logic [pm25_pkg::SAMPLE_W-1:0] average,
  input logic [pm25_pkg::LEVEL_W-1:0]  level_request,
  input logic                          clear_auto
);

  // reset leaves both sides open and nothing waiting
  `PM25_ASSERT_NEXT_ANY(a_reset_clears, rst, empty && !full)

  // a valid result asks to clear the auto request exactly when its window is full
  `PM25_ASSERT_NOW(a_clear_follows_full, !empty, clear_auto == window_full)

  // results during fill or while disabled carry no average or level
  `PM25_ASSERT_NOW(a_zero_when_not_full, !empty && !window_full,
                   average == '0 && level_request == pm25_pkg::LEVEL_NONE)

  // a waiting result is held while the receiver stalls
  `PM25_ASSERT_NEXT(a_hold_on_stall, !empty && !pop,
                    !empty && $stable(average) && $stable(level_request))

endmodule

bind pm25_average_fan_level_top pm25_checker u_pm25_checker (.*);
